/* src/mwnco_pkg.sv */
package mwnco_pkg;

   // pi/2 in unsigned Q30
   localparam logic [63:0] PIH_Q30 = 64'd1686629713;

   // Taylor series for sin(x): term k is divided by (2k+2)(2k+3)
   localparam int TAYLOR_TERMS = 12;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   // configuration register map, in units of 32-bit words
   localparam logic REG_PHASE_STEP  = 1'b0;
   localparam logic REG_WAVE_SELECT = 1'b1;

   localparam int STEP_BITS = 24;
   localparam int WAVE_BITS = 2;

   typedef enum logic [WAVE_BITS-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_SAWTOOTH = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   // One quarter-wave entry, evaluated at elaboration: sin(pi/2 * idx / 2^index_bits)
   // in Q30, floored after each multiply and divide, rounded half up to the
   // sample scale and clamped to positive full scale minus one.
   function automatic logic [63:0] sine_entry(input int unsigned idx,
                                              input int unsigned index_bits,
                                              input int unsigned sample_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        fs;
      logic [63:0]        r;
      x    = (PIH_Q30 * 64'(idx)) >> index_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
         term = (term * x2) >> 30;
         term = term / TAYLOR_DIV[k];
         if (k[0] == 1'b0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      fs = 64'd1 << (sample_bits - 1);
      r  = ($unsigned(sum) * fs + (64'd1 << 29)) >> 30;
      if (r > fs - 64'd1) begin
         r = fs - 64'd1;
      end
      return r;
   endfunction

endpackage

/* src/multi_waveform_nco_unit.sv */
// Phase-accumulator oscillator, one sample per tick beat.
// An accepted tick's sample reaches rsp_valid through the registered quarter-wave
// ROM read, then the output register.
// Throughput: one beat per cycle; the ROM read register and the output register
// form a two-deep pipeline that moves on whenever the output is free or taken.
// Reset (synchronous, active high) clears the phase, step, waveform and both valids.
module multi_waveform_nco_unit #(
   parameter int PHASE_BITS      = 24,
   parameter int SINE_INDEX_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   // sample channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import mwnco_pkg::*;

   localparam int QTAB_N   = 1 << SINE_INDEX_BITS;
   localparam int IDX_BITS = SINE_INDEX_BITS + 2;
   // widest phase slice any waveform takes
   localparam int TOP_BITS = (IDX_BITS > SAMPLE_BITS + 1) ? IDX_BITS : SAMPLE_BITS + 1;
   localparam int EXT_BITS = PHASE_BITS + TOP_BITS;
   localparam int MAG_BITS = SAMPLE_BITS - 1;

   localparam logic signed [SAMPLE_BITS-1:0] POS_FULL = {1'b0, {MAG_BITS{1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] NEG_FULL = {1'b1, {MAG_BITS{1'b0}}};
   localparam logic [SAMPLE_BITS+1:0]        TWO_FS   = (SAMPLE_BITS + 2)'(1) << SAMPLE_BITS;
   localparam logic [SAMPLE_BITS:0]          ONE_FS   = (SAMPLE_BITS + 1)'(1) << MAG_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [STEP_BITS-1:0] phase_step_ff;
   logic [WAVE_BITS-1:0] wave_select_ff;
   logic                 csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         wave_select_ff <= WAVE_SINE;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_PHASE_STEP:  phase_step_ff  <= csr_pwdata[STEP_BITS-1:0];
            REG_WAVE_SELECT: wave_select_ff <= csr_pwdata[WAVE_BITS-1:0];
            default:         phase_step_ff  <= phase_step_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_PHASE_STEP:  csr_prdata = 32'(phase_step_ff);
         REG_WAVE_SELECT: csr_prdata = 32'(wave_select_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Quarter-wave sine ROM, contents fixed at elaboration
   // ---------------------------------------------------------------------
   logic [MAG_BITS-1:0] rom_word [QTAB_N];

   for (genvar g = 0; g < QTAB_N; g++) begin : g_rom
      localparam logic [63:0] ENTRY = sine_entry(g, SINE_INDEX_BITS, SAMPLE_BITS);
      assign rom_word[g] = ENTRY[MAG_BITS-1:0];
   end

   // ---------------------------------------------------------------------
   // Handshake: the ROM stage advances into the output register whenever the
   // output register is empty or its beat is taken this cycle.
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic req_accept;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Stage 0: phase accumulator and ROM address
   // ---------------------------------------------------------------------
   logic [PHASE_BITS-1:0]      phase_accum_ff;
   logic [PHASE_BITS-1:0]      phase_accum_in;
   logic [PHASE_BITS-1:0]      phase_now;
   logic [PHASE_BITS-1:0]      step_masked;
   logic [PHASE_BITS+STEP_BITS-1:0] step_wide;
   logic [EXT_BITS-1:0]        ext0;
   logic [IDX_BITS-1:0]        idx0;
   logic [SINE_INDEX_BITS-1:0] rom_addr;

   // restart clears the phase before this tick's sample
   assign phase_now      = req_restart ? '0 : phase_accum_ff;
   // step is used zero-extended or truncated to the accumulator width
   assign step_wide      = {{PHASE_BITS{1'b0}}, phase_step_ff};
   assign step_masked    = step_wide[PHASE_BITS-1:0];
   assign phase_accum_in = phase_now + step_masked;

   assign ext0 = {phase_now, {TOP_BITS{1'b0}}};
   assign idx0 = ext0[EXT_BITS-1 -: IDX_BITS];
   // odd quadrants run the table backwards: address N-i, wrapped
   assign rom_addr = idx0[SINE_INDEX_BITS] ? (SINE_INDEX_BITS'(0) - idx0[SINE_INDEX_BITS-1:0])
                                           : idx0[SINE_INDEX_BITS-1:0];

   // ---------------------------------------------------------------------
   // Stage 1: registered ROM read, phase held alongside
   // ---------------------------------------------------------------------
   logic [PHASE_BITS-1:0] phase_s1_ff;
   logic [MAG_BITS-1:0]   rom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_accum_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_accum_ff <= phase_accum_in;
            s1_valid_ff    <= 1'b1;
         end else if (advance) begin
            s1_valid_ff    <= 1'b0;
         end
      end
      // payload: hold while stalled
      if (req_accept) begin
         phase_s1_ff <= phase_now;
         rom_ff      <= rom_word[rom_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: waveform shaping into the output register
   // ---------------------------------------------------------------------
   logic [EXT_BITS-1:0]              ext1;
   logic [IDX_BITS-1:0]              idx1;
   logic [SAMPLE_BITS-1:0]           saw_top;
   logic [SAMPLE_BITS:0]             tri_w;
   logic [SAMPLE_BITS+1:0]           tri_diff;
   logic signed [SAMPLE_BITS-1:0]    sine_mag;
   logic signed [SAMPLE_BITS-1:0]    sine_val;
   logic signed [SAMPLE_BITS-1:0]    tri_val;
   logic signed [SAMPLE_BITS-1:0]    sample_in;
   logic signed [SAMPLE_BITS-1:0]    rsp_sample_ff;

   assign ext1    = {phase_s1_ff, {TOP_BITS{1'b0}}};
   assign idx1    = ext1[EXT_BITS-1 -: IDX_BITS];
   assign saw_top = ext1[EXT_BITS-1 -: SAMPLE_BITS];
   assign tri_w   = ext1[EXT_BITS-1 -: SAMPLE_BITS + 1];

   always_comb begin
      // sine: peak of an odd quadrant at index zero sits past the table end
      if (idx1[SINE_INDEX_BITS] && (idx1[SINE_INDEX_BITS-1:0] == '0)) begin
         sine_mag = POS_FULL;
      end else begin
         sine_mag = $signed({1'b0, rom_ff});
      end
      sine_val = idx1[SINE_INDEX_BITS+1] ? -sine_mag : sine_mag;

      // triangle: rising below FS, falling to -FS, rising again from 3FS
      tri_diff = TWO_FS - {1'b0, tri_w};
      case (tri_w[SAMPLE_BITS:SAMPLE_BITS-1])
         2'b00:   tri_val = $signed(tri_w[SAMPLE_BITS-1:0]);
         2'b11:   tri_val = $signed(tri_w[SAMPLE_BITS-1:0]);
         default: tri_val = (tri_w == ONE_FS) ? POS_FULL
                                               : $signed(tri_diff[SAMPLE_BITS-1:0]);
      endcase

      case (wave_type'(wave_select_ff))
         WAVE_SINE:     sample_in = sine_val;
         WAVE_SQUARE:   sample_in = phase_s1_ff[PHASE_BITS-1] ? NEG_FULL : POS_FULL;
         // subtracting FS flips the sign bit
         WAVE_SAWTOOTH: sample_in = $signed({~saw_top[SAMPLE_BITS-1],
                                             saw_top[SAMPLE_BITS-2:0]});
         WAVE_TRIANGLE: sample_in = tri_val;
         default:       sample_in = sine_val;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (advance && s1_valid_ff) begin
         rsp_sample_ff <= sample_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

/* src/mwnco_checker.sv */
module mwnco_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_sample
);

   // a stalled sample beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled sample beat changed or dropped");

   // ticks back up only when the output is stalled with a sample waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("tick stalled while sample side is free");

   // accepted tick reaches the output register when not held back by a stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("sample missing two cycles after tick");

   // nothing comes out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("sample valid right after reset");

endmodule

bind multi_waveform_nco_unit mwnco_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mwnco_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sample (rsp_sample)
);
